// File: rtl/button_click_hold_classifier_macros.svh
// ---------------------------------------------------------------------------
// Button click/hold classifier: assertion macros
// Concurrent check wrappers sampled on the block clock, held off in reset.
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_HOLD_CLASSIFIER_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define BCHC_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a consequent follows an antecedent in the next cycle.
`define BCHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bchc_pkg.sv
// ---------------------------------------------------------------------------
// Button click/hold classifier package
// Shared widths, operation codes and state, config and result types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bchc_pkg;

   localparam int TICK_W   = 7;
   localparam int COUNT_W  = 4;
   localparam int KIND_W   = 3;
   localparam int MODE_W   = 3;
   localparam int INDEX_W  = 2;

   localparam logic [COUNT_W-1:0] MAX_CLICKS     = 4'd10;
   localparam logic [COUNT_W-1:0] MAX_HOLD_KIND  = 4'd4;

   // Operation codes carried in the request tuser
   localparam logic [MODE_W-1:0] MODE_KEY      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TICK     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_EVAL     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLICKS   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LONG     = 3'd4;

   // Register indexes on the csr port
   localparam logic [INDEX_W-1:0] REG_LONG_PRESS   = 2'd0;
   localparam logic [INDEX_W-1:0] REG_CLICK_WINDOW = 2'd1;
   localparam logic [INDEX_W-1:0] REG_ACTIVE_HIGH  = 2'd2;

   localparam logic [TICK_W-1:0] LONG_PRESS_RESET   = 7'd16;
   localparam logic [TICK_W-1:0] CLICK_WINDOW_RESET = 7'd4;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [TICK_W-1:0] long_press_ticks;
      logic [TICK_W-1:0] click_window_ticks;
      logic              active_high;
   } cfg_type;

   typedef struct packed {
      logic               pressed;
      logic               press_run;
      logic [TICK_W-1:0]  press_ticks;
      logic               window_run;
      logic [TICK_W-1:0]  window_ticks;
      logic [COUNT_W-1:0] burst_count;
      logic               burst_done;
      logic               long_seen;
      logic               long_pending;
      logic [KIND_W-1:0]  hold_kind;
   } state_type;

   typedef struct packed {
      logic               any_hold;
      logic [KIND_W-1:0]  hold_clicks;
      logic               hold_active;
      logic               long_press_event;
      logic [COUNT_W-1:0] click_count;
      logic               key_down;
   } result_type;

   localparam state_type STATE_RESET = '{
      pressed: 1'b0, press_run: 1'b0, press_ticks: '0, window_run: 1'b0,
      window_ticks: '0, burst_count: '0, burst_done: 1'b0, long_seen: 1'b0,
      long_pending: 1'b0, hold_kind: '0
   };

endpackage

// File: rtl/bchc_core.sv
// ---------------------------------------------------------------------------
// Button click/hold classifier: update logic
// Next state and result for one transaction, from current state and config.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bchc_core (
   input  bchc_pkg::state_type             state_cur,
   input  bchc_pkg::cfg_type               cfg,
   input  logic [bchc_pkg::MODE_W-1:0]     mode,
   input  logic                            key_level,
   input  logic                            consume,
   output bchc_pkg::state_type             state_nxt,
   output bchc_pkg::result_type            result
);
   import bchc_pkg::*;

   state_type          s;
   logic [COUNT_W-1:0] clicks;
   logic               longev;
   logic               down;
   logic [TICK_W-1:0]  held;
   logic [COUNT_W-1:0] n;

   always_comb begin
      s      = state_cur;
      clicks = '0;
      longev = 1'b0;
      down   = cfg.active_high ? key_level : ~key_level;
      held   = state_cur.press_ticks;
      n      = state_cur.burst_count;

      unique case (mode)
         MODE_KEY: begin
            if (down) begin
               s.pressed = 1'b1;
               if (s.window_run) s.window_ticks = '0;
               if (!s.press_run) begin
                  s.press_run   = 1'b1;
                  s.press_ticks = '0;
               end
            end else begin
               s.pressed     = 1'b0;
               s.press_run   = 1'b0;
               s.press_ticks = '0;
               if (s.long_seen || (s.hold_kind != '0)) begin
                  // release after a hold: no click
                  s.hold_kind = '0;
                  s.long_seen = 1'b0;
               end else if (held < cfg.long_press_ticks) begin
                  if (s.burst_count < MAX_CLICKS) s.burst_count = s.burst_count + COUNT_W'(1);
                  s.window_run   = 1'b1;
                  s.window_ticks = '0;
               end
            end
         end
         MODE_TICK: begin
            if (!s.press_run) s.press_ticks = '0;
            else if (s.press_ticks < cfg.long_press_ticks)
               s.press_ticks = s.press_ticks + TICK_W'(1);
            if (!s.window_run) s.window_ticks = '0;
            else if (s.window_ticks < cfg.click_window_ticks)
               s.window_ticks = s.window_ticks + TICK_W'(1);
         end
         MODE_EVAL: begin
            if (s.pressed && s.window_run) s.window_ticks = '0;
            if (s.pressed && s.press_run && (s.press_ticks == cfg.long_press_ticks)) begin
               if (n != '0) begin
                  // click-then-hold: drop the burst, bursts above four give no kind
                  s.window_run   = 1'b0;
                  s.window_ticks = '0;
                  s.burst_done   = 1'b0;
                  s.burst_count  = '0;
                  s.long_seen    = 1'b0;
                  s.long_pending = 1'b0;
                  s.hold_kind    = (n <= MAX_HOLD_KIND) ? n[KIND_W-1:0] : '0;
               end else begin
                  s.hold_kind    = '0;
                  s.long_pending = 1'b1;
                  s.long_seen    = 1'b1;
               end
               s.press_run   = 1'b0;
               s.press_ticks = '0;
            end
            if (!s.pressed && s.window_run && (s.window_ticks == cfg.click_window_ticks)) begin
               s.window_run   = 1'b0;
               s.window_ticks = '0;
               if (!s.long_seen) s.burst_done = 1'b1;
               else              s.long_seen  = 1'b0;
            end
         end
         MODE_CLICKS: begin
            if (!s.long_seen && s.burst_done) begin
               clicks = s.burst_count;
               if (consume) begin
                  s.burst_done  = 1'b0;
                  s.burst_count = '0;
               end
            end
         end
         MODE_LONG: begin
            longev         = s.long_pending;
            s.long_pending = 1'b0;
         end
         default: begin
         end
      endcase

      state_nxt                 = s;
      result.key_down           = s.pressed;
      result.click_count        = clicks;
      result.long_press_event   = longev;
      result.hold_active        = s.long_seen;
      result.hold_clicks        = s.hold_kind;
      result.any_hold           = s.long_seen || (s.hold_kind != '0);
   end

endmodule

// File: rtl/button_click_hold_classifier.sv
// A transaction accepted at one edge shows its result after that edge.
// Throughput: one transaction per cycle unless the response stalls; the state update
//   is a single pass of flag and counter logic between state and result registers.
// Reset: synchronous, active high; clears the classifier state, empties the result
//   register and loads the register defaults (long press 16, window 4, active low).
`timescale 1ns / 1ps
`include "button_click_hold_classifier_macros.svh"
// ---------------------------------------------------------------------------
// Button click/hold classifier
// Sorts key activity into click bursts, long press and click-then-hold.
// ---------------------------------------------------------------------------

module button_click_hold_classifier (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bchc_pkg::REQ_DATA_W-1:0]     req_tdata,  // [0] key_level, [1] consume
   input  logic [bchc_pkg::MODE_W-1:0]         req_tuser,  // [2:0] mode
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bchc_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [0] key_down,
                                                           // [4:1] click_count,
                                                           // [5] long_press_event,
                                                           // [6] hold_active,
                                                           // [9:7] hold_clicks,
                                                           // [10] any_hold
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bchc_pkg::INDEX_W-1:0]        csr_index,
   input  logic [bchc_pkg::TICK_W-1:0]         csr_data
);
   import bchc_pkg::*;

   localparam int RES_W = $bits(result_type);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   result_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire;
   state_type  core_state;
   result_type core_result;

   // Accept while the result register is empty or being drained this cycle
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   bchc_core u_core (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .mode      (req_tuser),
      .key_level (req_tdata[0]),
      .consume   (req_tdata[1]),
      .state_nxt (core_state),
      .result    (core_result)
   );

   // Register writes; an index beyond the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LONG_PRESS:   cfg_in.long_press_ticks   = csr_data;
            REG_CLICK_WINDOW: cfg_in.click_window_ticks = csr_data;
            REG_ACTIVE_HIGH:  cfg_in.active_high        = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Advance state and load the result on every accepted transaction
   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (req_fire) begin
         state_in     = core_state;
         res_in       = core_result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks   <= LONG_PRESS_RESET;
         cfg_ff.click_window_ticks <= CLICK_WINDOW_RESET;
         cfg_ff.active_high        <= 1'b0;
         state_ff                  <= STATE_RESET;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload holds without reset
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RES_W){1'b0}}, res_ff};

   // Checks
   `BCHC_ASSERT(a_hold_exclusive, !(state_ff.long_seen && (state_ff.hold_kind != '0)), "plain long press and click-hold both active")
   `BCHC_ASSERT(a_counts_in_range, (state_ff.burst_count <= MAX_CLICKS) && ({1'b0, state_ff.hold_kind} <= MAX_HOLD_KIND), "burst count or hold kind out of range")
   `BCHC_ASSERT(a_any_hold_flag, !rsp_valid_ff || (res_ff.any_hold == (res_ff.hold_active || (res_ff.hold_clicks != '0))), "any_hold disagrees with hold flags")
   `BCHC_ASSERT_NEXT(a_result_follows, req_fire, rsp_valid_ff, "accepted transaction produced no result")

endmodule

// File: tb/sv/tb_button_click_hold_classifier.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button click/hold classifier testbench
// Streams key changes, ticks, evaluations and fetches into the classifier,
// predicts each response with an in-bench gesture tracker and compares every
// response field by field, under random idling on both streams.
// ---------------------------------------------------------------------------

module tb_button_click_hold_classifier;
   import bchc_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 7;
   localparam int STALL_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 4;
   localparam int PRINT_LIMIT  = 30;

   // Codes the block must ignore: first unused mode and the unused register slot
   localparam logic [MODE_W-1:0]  MODE_SPARE = 3'd5;
   localparam logic [INDEX_W-1:0] REG_SPARE  = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [0] key_level, [1] consume
   logic [MODE_W-1:0]     req_tuser  = '0;  // [2:0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [0] key_down, [4:1] click_count,
                                            // [5] long_press_event, [6] hold_active,
                                            // [9:7] hold_clicks, [10] any_hold
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [INDEX_W-1:0]    csr_index  = '0;
   logic [TICK_W-1:0]     csr_data   = '0;

   // Gesture tracker: the bench's own copy of the registers and classifier state
   cfg_type    tracked_cfg;
   state_type  tracked_gesture;
   result_type gesture_reports_due[$];

   int send_idle_pct   = 34;
   int recv_idle_pct   = 76;
   int mismatch_count  = 0;
   int items_sent      = 0;
   int reports_checked = 0;
   int quiet_cycles    = 0;

   button_click_hold_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Gesture tracker
   // -------------------------------------------------------------------------

   // A running timer counts up to its threshold and sits there; a stopped one reads 0.
   // A timer already past a lowered threshold is left where it is.
   function automatic logic [TICK_W-1:0] timer_advance(logic running,
                                                       logic [TICK_W-1:0] count,
                                                       logic [TICK_W-1:0] threshold);
      if (!running) return '0;
      if (count < threshold) return count + TICK_W'(1);
      return count;
   endfunction

   // Apply one transaction to the tracked state and return the response it must produce.
   function automatic result_type classify_step(logic [MODE_W-1:0] mode, logic level,
                                                logic consume);
      result_type         report;
      logic               down;
      logic [TICK_W-1:0]  held;
      logic [COUNT_W-1:0] burst;
      report = '0;
      case (mode)
         MODE_KEY: begin
            down = tracked_cfg.active_high ? level : !level;
            if (down) begin
               tracked_gesture.pressed = 1'b1;
               if (tracked_gesture.window_run) tracked_gesture.window_ticks = '0;
               // a repeated press edge keeps the press timer running
               if (!tracked_gesture.press_run) begin
                  tracked_gesture.press_run   = 1'b1;
                  tracked_gesture.press_ticks = '0;
               end
            end else begin
               held = tracked_gesture.press_ticks;
               tracked_gesture.pressed     = 1'b0;
               tracked_gesture.press_run   = 1'b0;
               tracked_gesture.press_ticks = '0;
               if (tracked_gesture.long_seen || tracked_gesture.hold_kind != '0) begin
                  // release ends a hold and counts no click
                  tracked_gesture.hold_kind = '0;
                  tracked_gesture.long_seen = 1'b0;
               end else if (held < tracked_cfg.long_press_ticks) begin
                  if (tracked_gesture.burst_count < MAX_CLICKS)
                     tracked_gesture.burst_count = tracked_gesture.burst_count + COUNT_W'(1);
                  tracked_gesture.window_run   = 1'b1;
                  tracked_gesture.window_ticks = '0;
               end
            end
         end
         MODE_TICK: begin
            tracked_gesture.press_ticks = timer_advance(tracked_gesture.press_run,
               tracked_gesture.press_ticks, tracked_cfg.long_press_ticks);
            tracked_gesture.window_ticks = timer_advance(tracked_gesture.window_run,
               tracked_gesture.window_ticks, tracked_cfg.click_window_ticks);
         end
         MODE_EVAL: begin
            if (tracked_gesture.pressed && tracked_gesture.window_run)
               tracked_gesture.window_ticks = '0;
            if (tracked_gesture.pressed && tracked_gesture.press_run &&
                tracked_gesture.press_ticks == tracked_cfg.long_press_ticks) begin
               if (tracked_gesture.burst_count != '0) begin
                  // clicks then hold: bursts longer than four give no hold kind
                  burst = tracked_gesture.burst_count;
                  tracked_gesture.window_run   = 1'b0;
                  tracked_gesture.window_ticks = '0;
                  tracked_gesture.burst_done   = 1'b0;
                  tracked_gesture.burst_count  = '0;
                  tracked_gesture.long_seen    = 1'b0;
                  tracked_gesture.long_pending = 1'b0;
                  tracked_gesture.hold_kind    = (burst <= MAX_HOLD_KIND) ?
                                                 burst[KIND_W-1:0] : '0;
               end else begin
                  tracked_gesture.hold_kind    = '0;
                  tracked_gesture.long_pending = 1'b1;
                  tracked_gesture.long_seen    = 1'b1;
               end
               tracked_gesture.press_run   = 1'b0;
               tracked_gesture.press_ticks = '0;
            end
            if (!tracked_gesture.pressed && tracked_gesture.window_run &&
                tracked_gesture.window_ticks == tracked_cfg.click_window_ticks) begin
               tracked_gesture.window_run   = 1'b0;
               tracked_gesture.window_ticks = '0;
               if (!tracked_gesture.long_seen) tracked_gesture.burst_done = 1'b1;
               else                            tracked_gesture.long_seen  = 1'b0;
            end
         end
         MODE_CLICKS: begin
            if (!tracked_gesture.long_seen && tracked_gesture.burst_done) begin
               report.click_count = tracked_gesture.burst_count;
               if (consume) begin
                  tracked_gesture.burst_done  = 1'b0;
                  tracked_gesture.burst_count = '0;
               end
            end
         end
         MODE_LONG: begin
            report.long_press_event      = tracked_gesture.long_pending;
            tracked_gesture.long_pending = 1'b0;
         end
         default: begin
         end
      endcase
      report.key_down    = tracked_gesture.pressed;
      report.hold_active = tracked_gesture.long_seen;
      report.hold_clicks = tracked_gesture.hold_kind;
      report.any_hold    = tracked_gesture.long_seen || (tracked_gesture.hold_kind != '0);
      return report;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Offer one transaction, idling first at the sender's rate; predict on acceptance.
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic level,
                            input logic consume);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_DATA_W - 2){1'b0}}, consume, level};
      do @(posedge clock); while (!req_tready);
      gesture_reports_due.push_back(classify_step(mode, level, consume));
      items_sent++;
   endtask

   // Operations whose level and consume bits do not matter: randomise them.
   task automatic send_op(input logic [MODE_W-1:0] mode);
      send_item(mode, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic key_press();
      send_item(MODE_KEY, tracked_cfg.active_high, 1'($urandom_range(1)));
   endtask

   task automatic key_release();
      send_item(MODE_KEY, !tracked_cfg.active_high, 1'($urandom_range(1)));
   endtask

   task automatic fetch_clicks(input logic consume);
      send_item(MODE_CLICKS, 1'($urandom_range(1)), consume);
   endtask

   // Hold the request stream until every predicted response has been checked.
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (gesture_reports_due.size() != 0);
   endtask

   task automatic write_register(input logic [INDEX_W-1:0] index,
                                 input logic [TICK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (index)
         REG_LONG_PRESS:   tracked_cfg.long_press_ticks   = value;
         REG_CLICK_WINDOW: tracked_cfg.click_window_ticks = value;
         REG_ACTIVE_HIGH:  tracked_cfg.active_high        = value[0];
         default: begin
         end
      endcase
   endtask

   task automatic configure(input logic [TICK_W-1:0] long_press,
                            input logic [TICK_W-1:0] window, input logic [TICK_W-1:0] polarity);
      hold_until_drained();
      write_register(REG_LONG_PRESS, long_press);
      write_register(REG_CLICK_WINDOW, window);
      write_register(REG_ACTIVE_HIGH, polarity);
   endtask

   // Ticks with evaluations scattered between them, closed by one evaluation.
   task automatic run_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         send_op(MODE_TICK);
         if ($urandom_range(3) == 0) send_op(MODE_EVAL);
      end
      send_op(MODE_EVAL);
   endtask

   // Span below a threshold, mostly short so that large thresholds stay cheap.
   function automatic int brief_span(int threshold);
      if (threshold <= 0) return 0;
      if ($urandom_range(7) == 0) return $urandom_range(threshold - 1);
      return $urandom_range((threshold - 1 < 3) ? threshold - 1 : 3);
   endfunction

   // One well-formed gesture with random content, trailed by a little noise.
   task automatic run_gesture();
      int clicks;
      int long_press;
      int window;
      long_press = tracked_cfg.long_press_ticks;
      window     = tracked_cfg.click_window_ticks;
      case ($urandom_range(3))
         0:       clicks = 0;
         1, 2:    clicks = $urandom_range(4, 1);
         default: clicks = $urandom_range(12, 5);
      endcase
      for (int i = 0; i < clicks; i++) begin
         key_press();
         if ($urandom_range(5) == 0) key_press();  // bounce: second press edge
         run_ticks(brief_span(long_press));
         key_release();
         if (i + 1 < clicks) run_ticks(brief_span(window));
      end
      if ($urandom_range(1)) begin
         key_press();
         run_ticks(long_press + $urandom_range(2));
         if ($urandom_range(1)) send_op(MODE_LONG);
         key_release();
      end
      run_ticks(window + $urandom_range(1));
      fetch_clicks(1'($urandom_range(1)));
      if ($urandom_range(1)) fetch_clicks(1'b1);
      send_op(MODE_LONG);
      repeat ($urandom_range(3)) send_op(MODE_W'($urandom_range(7)));
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Two quick clicks, window expiry, fetch without and with consume, unused modes.
   task automatic test_click_burst();
      configure(7'd2, 7'd1, 7'd0);
      key_press();
      key_release();
      key_press();
      key_release();
      send_op(MODE_TICK);
      send_op(MODE_EVAL);
      fetch_clicks(1'b0);
      fetch_clicks(1'b1);
      fetch_clicks(1'b0);
      send_op(MODE_SPARE);
      send_op(MODE_SPARE + 3'd1);
      send_op(MODE_SPARE + 3'd2);
   endtask

   // One click then a hold, then a plain long press with its event fetched twice.
   task automatic test_hold_kinds();
      key_press();
      key_release();
      key_press();
      send_op(MODE_TICK);
      send_op(MODE_TICK);
      send_op(MODE_EVAL);
      key_release();
      key_press();
      send_op(MODE_TICK);
      send_op(MODE_TICK);
      send_op(MODE_EVAL);
      send_op(MODE_LONG);
      send_op(MODE_LONG);
      key_release();
   endtask

   // Zero thresholds, active-high key: long at first evaluation, no release is a click.
   task automatic test_zero_thresholds();
      configure(7'd0, 7'd0, 7'd1);
      key_press();
      send_op(MODE_EVAL);
      key_release();
      key_press();
      key_release();
      send_op(MODE_EVAL);
      send_op(MODE_LONG);
   endtask

   // Press timer left above a threshold lowered mid-press; the unused register slot.
   task automatic test_lowered_threshold();
      configure(7'd10, 7'd5, 7'd0);
      key_press();
      repeat (4) send_op(MODE_TICK);
      hold_until_drained();
      write_register(REG_LONG_PRESS, 7'd2);
      write_register(REG_SPARE, 7'h55);
      send_op(MODE_TICK);
      send_op(MODE_EVAL);
      key_release();
      fetch_clicks(1'b1);
   endtask

   task automatic test_random_gestures(input int target);
      int stop_at;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         run_gesture();
         // now and then let the pipe run dry before carrying on
         if ($urandom_range(7) == 0) hold_until_drained();
      end
   endtask

   // -------------------------------------------------------------------------
   // Response checking
   // -------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int wanted);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns response %0d: %s got %0d, predicted %0d",
                  $realtime, reports_checked, what, got, wanted);
   endtask

   task automatic compare_field(input string what, input int got, input int wanted);
      if (got != wanted) report_mismatch(what, got, wanted);
   endtask

   // Receiver back-pressure at the current idling rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Match each accepted response against the oldest prediction
   always @(posedge clock) begin : check_responses
      result_type seen;
      result_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (gesture_reports_due.size() == 0) begin
            report_mismatch("response with nothing predicted, raw", int'(seen), 0);
         end else begin
            wanted = gesture_reports_due.pop_front();
            compare_field("key_down", int'(seen.key_down), int'(wanted.key_down));
            compare_field("click_count", int'(seen.click_count), int'(wanted.click_count));
            compare_field("long_press_event", int'(seen.long_press_event),
                          int'(wanted.long_press_event));
            compare_field("hold_active", int'(seen.hold_active), int'(wanted.hold_active));
            compare_field("hold_clicks", int'(seen.hold_clicks), int'(wanted.hold_clicks));
            compare_field("any_hold", int'(seen.any_hold), int'(wanted.any_hold));
         end
         reports_checked++;
      end
   end

   // Watchdog: abort when no transaction moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      tracked_cfg = '{long_press_ticks: LONG_PRESS_RESET,
                      click_window_ticks: CLICK_WINDOW_RESET, active_high: 1'b0};
      tracked_gesture = STATE_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed cases, sender sparse idling, receiver heavy stalling
      test_click_burst();
      test_hold_kinds();
      test_zero_thresholds();
      test_lowered_threshold();

      // Reset defaults, active-low key
      configure(LONG_PRESS_RESET, CLICK_WINDOW_RESET, 7'h7E);
      test_random_gestures(450);

      // Largest thresholds, active-high key; swap idling rates
      hold_until_drained();
      send_idle_pct = 76;
      recv_idle_pct = 34;
      configure(7'd127, 7'd127, 7'd1);
      test_random_gestures(400);

      // Smallest nonzero thresholds, full rate on both sides
      hold_until_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(7'd1, 7'd1, 7'd0);
      test_random_gestures(300);

      // Assorted moderate settings at full rate
      repeat (4) begin
         configure(TICK_W'($urandom_range(12, 1)), TICK_W'($urandom_range(12, 1)),
                   TICK_W'($urandom_range(127)));
         test_random_gestures(100);
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bchc_pkg.sv
rtl/bchc_core.sv
rtl/button_click_hold_classifier.sv
tb/sv/tb_button_click_hold_classifier.sv
